/* design/gdau_pkg.sv */
// ---------------------------------------------------------------------------
// Gregorian date arithmetic package
// Shared widths, constants, the month offset table and the types that pass
// between the stages of the date arithmetic unit.
// ---------------------------------------------------------------------------
package gdau_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int OFF_W  = 23;
    localparam int DN_W   = 23;
    localparam int NUM_W  = 22;

    localparam logic [0:0] CMD_ADD  = 1'b0;
    localparam logic [0:0] CMD_DIFF = 1'b1;

    // Day numbers count from 1 March of year -400.
    localparam logic [17:0] ERA_DAYS = 18'd146097;
    localparam logic [21:0] DN_LO    = 22'd146037;
    localparam logic [21:0] DN_HI    = 22'd3798461;

    localparam logic [22:0] DIFF_MAX = 23'h3FFFFF;
    localparam logic [22:0] DIFF_MIN = 23'h400000;

    // Reciprocal constants for division by constants: q = (x * RCP) >> SH.
    localparam logic [12:0] RCP_100     = 13'd5243;
    localparam int          RCP_100_SH  = 19;
    localparam logic [22:0] RCP_ERA     = 23'd7525902;
    localparam int          RCP_ERA_SH  = 40;
    localparam logic [17:0] RCP_1460    = 18'd183860;
    localparam int          RCP_1460_SH = 28;
    localparam logic [17:0] RCP_365     = 18'd183860;
    localparam int          RCP_365_SH  = 26;
    localparam logic [5:0]  RCP_YOE100  = 6'd41;
    localparam int          RCP_YOE_SH  = 12;
    // (5 * doy + 2) / 153 folded into one product: doy * 34270 + 13708.
    localparam logic [15:0] MP_MUL      = 16'd34270;
    localparam logic [13:0] MP_ADD      = 14'd13708;
    localparam int          MP_SH       = 20;

    typedef struct packed {
        logic              cmd;
        logic              err;
        logic signed [22:0] diff;
    } t_side;

    // Days from 1 March to the first of the month, months counted from March.
    function automatic logic [8:0] month_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

/* design/gdau_to_days.sv */
// ---------------------------------------------------------------------------
// Date to day number
// Two register stages: month clamp, year shift and century quotient first,
// then the weighted sum that gives the day number.
// ---------------------------------------------------------------------------
module gdau_to_days
    import gdau_pkg::*;
(
    input  logic              i_clk,
    input  logic [YEAR_W-1:0] i_year,
    input  logic [MON_W-1:0]  i_month,
    input  logic [DAY_W-1:0]  i_day,
    output logic [DN_W-1:0]   o_day_num
);

    logic [3:0]  mon_sat;
    logic [3:0]  mp;
    logic        jan_feb;
    logic [14:0] year_adj;
    logic [27:0] q100_prod;

    logic [14:0] r_year, n_year;
    logic [7:0]  r_q100, n_q100;
    logic [8:0]  r_base, n_base;
    logic [4:0]  r_day,  n_day;
    logic [22:0] r_dn,   n_dn;

    always_comb begin
        if (i_month == 4'd0) begin
            mon_sat = 4'd1;
        end else if (i_month > 4'd12) begin
            mon_sat = 4'd12;
        end else begin
            mon_sat = i_month;
        end
        jan_feb   = (mon_sat <= 4'd2);
        mp        = jan_feb ? (mon_sat + 4'd9) : (mon_sat - 4'd3);
        year_adj  = {1'b0, i_year} + 15'd400 - {14'd0, jan_feb};
        q100_prod = 28'(year_adj) * 28'(RCP_100);
        n_year    = year_adj;
        n_q100    = q100_prod[RCP_100_SH+7:RCP_100_SH];
        n_base    = month_base(mp);
        n_day     = i_day;
    end

    // 365y + y/4 - y/100 + y/400 + day of year; a day of 0 steps back one.
    always_comb begin
        n_dn = 23'(r_year) * 23'd365
             + 23'(r_year[14:2])
             - 23'(r_q100)
             + 23'(r_q100[7:2])
             + 23'(r_base)
             + 23'(r_day)
             - 23'd1;
    end

    always_ff @(posedge i_clk) begin
        r_year <= n_year;
        r_q100 <= n_q100;
        r_base <= n_base;
        r_day  <= n_day;
        r_dn   <= n_dn;
    end

    assign o_day_num = r_dn;

endmodule

/* design/gdau_to_date.sv */
// ---------------------------------------------------------------------------
// Day number to date
// Eight register stages: era, day of era, the 4/100/400 corrections, year of
// era, day of year, month index and finally the calendar fields.
// ---------------------------------------------------------------------------
module gdau_to_date
    import gdau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [NUM_W-1:0]  i_day_num,
    output logic              o_valid,
    output t_side             o_side,
    output logic [YEAR_W-1:0] o_year,
    output logic [MON_W-1:0]  o_month,
    output logic [DAY_W-1:0]  o_day
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] r_valid;
    t_side             r_side [STAGES];

    // Stage 1: era.
    logic [44:0] era_prod;
    logic [4:0]  r1_era;
    logic [21:0] r1_dn;
    // Stage 2: day of era.
    logic [17:0] r2_doe;
    logic [4:0]  r2_era;
    // Stage 3: quotients by 1460, 36524 and 146096.
    logic [35:0] q1460_prod;
    logic [2:0]  q36524;
    logic [17:0] r3_doe;
    logic [4:0]  r3_era;
    logic [6:0]  r3_q1460;
    logic [2:0]  r3_q36524;
    logic        r3_qera;
    // Stage 4: corrected day count.
    logic [17:0] r4_x;
    logic [17:0] r4_doe;
    logic [4:0]  r4_era;
    // Stage 5: year of era.
    logic [35:0] yoe_prod;
    logic [8:0]  r5_yoe;
    logic [17:0] r5_doe;
    logic [4:0]  r5_era;
    // Stage 6: day of year.
    logic [14:0] yoe100_prod;
    logic [17:0] year_days;
    logic [8:0]  r6_doy;
    logic [8:0]  r6_yoe;
    logic [4:0]  r6_era;
    // Stage 7: month index from March.
    logic [23:0] mp_prod;
    logic [3:0]  r7_mp;
    logic [8:0]  r7_doy;
    logic [8:0]  r7_yoe;
    logic [4:0]  r7_era;
    // Stage 8: calendar fields.
    logic        late_mon;
    logic [15:0] year_full;
    logic [8:0]  day_full;
    logic [YEAR_W-1:0] r8_year;
    logic [MON_W-1:0]  r8_month;
    logic [DAY_W-1:0]  r8_day;

    always_comb begin
        era_prod    = 45'(i_day_num) * 45'(RCP_ERA);
        q1460_prod  = 36'(r2_doe) * 36'(RCP_1460);
        q36524      = 3'(r2_doe >= 18'd36524) + 3'(r2_doe >= 18'd73048)
                    + 3'(r2_doe >= 18'd109572) + 3'(r2_doe >= 18'd146096);
        yoe_prod    = 36'(r4_x) * 36'(RCP_365);
        yoe100_prod = 15'(r5_yoe) * 15'(RCP_YOE100);
        year_days   = 18'(r5_yoe) * 18'd365 + 18'(r5_yoe[8:2])
                    - 18'(yoe100_prod[RCP_YOE_SH+2:RCP_YOE_SH]);
        mp_prod     = 24'(r6_doy) * 24'(MP_MUL) + 24'(MP_ADD);
        late_mon    = (r7_mp >= 4'd10);
        year_full   = 16'(r7_yoe) + 16'(r7_era) * 16'd400 + 16'(late_mon) - 16'd400;
        day_full    = r7_doy - month_base(r7_mp) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int s = 1; s < STAGES; s++) begin
            r_side[s] <= r_side[s-1];
        end

        r1_era <= era_prod[RCP_ERA_SH+4:RCP_ERA_SH];
        r1_dn  <= i_day_num;

        r2_doe <= 18'(r1_dn - 22'(22'(r1_era) * 22'(ERA_DAYS)));
        r2_era <= r1_era;

        r3_doe    <= r2_doe;
        r3_era    <= r2_era;
        r3_q1460  <= q1460_prod[RCP_1460_SH+6:RCP_1460_SH];
        r3_q36524 <= q36524;
        r3_qera   <= (r2_doe == 18'd146096);

        r4_x   <= r3_doe - 18'(r3_q1460) + 18'(r3_q36524) - 18'(r3_qera);
        r4_doe <= r3_doe;
        r4_era <= r3_era;

        r5_yoe <= yoe_prod[RCP_365_SH+8:RCP_365_SH];
        r5_doe <= r4_doe;
        r5_era <= r4_era;

        r6_doy <= 9'(r5_doe - year_days);
        r6_yoe <= r5_yoe;
        r6_era <= r5_era;

        r7_mp  <= mp_prod[MP_SH+3:MP_SH];
        r7_doy <= r6_doy;
        r7_yoe <= r6_yoe;
        r7_era <= r6_era;

        r8_year  <= year_full[YEAR_W-1:0];
        r8_month <= late_mon ? (r7_mp - 4'd9) : (r7_mp + 4'd3);
        r8_day   <= day_full[DAY_W-1:0];
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_year  = r8_year;
    assign o_month = r8_month;
    assign o_day   = r8_day;

endmodule

/* design/gregorian_date_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// Gregorian date arithmetic unit
// Adds a signed day offset to a date, or counts the days between two dates.
// ---------------------------------------------------------------------------
// A request is taken at every rising edge where start is high; busy is never
// raised, so one request may follow another in every cycle. The command
// selects the operation: add i_day_offset to the first date, or return the
// signed number of days from the first date to the second.
// Both dates go through a two-stage day number conversion, one stage then
// adds the offset or subtracts the day numbers with saturation, and an
// eight-stage pipeline turns the day number back into a date. One output
// register follows. The result of a request is on the o_ ports with o_valid
// high for exactly one cycle; results keep request order, one per cycle.
// A shifted date outside years 0..9999 is clamped to the nearest end and
// raises o_range_error; the unused fields of a result read as zero.
// Reset clears the valid bits of every stage, so requests in flight are
// dropped. The receiver has no way to stall the unit and must take each
// result in the cycle it is shown.
// ---------------------------------------------------------------------------
module gregorian_date_arithmetic_unit
    import gdau_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic [YEAR_W-1:0]       i_first_year,
    input  logic [MON_W-1:0]        i_first_month,
    input  logic [DAY_W-1:0]        i_first_day,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  logic [YEAR_W-1:0]       i_second_year,
    input  logic [MON_W-1:0]        i_second_month,
    input  logic [DAY_W-1:0]        i_second_day,
    output logic                    o_valid,
    output logic [YEAR_W-1:0]       o_result_year,
    output logic [MON_W-1:0]        o_result_month,
    output logic [DAY_W-1:0]        o_result_day,
    output logic signed [OFF_W-1:0] o_day_difference,
    output logic                    o_range_error
);

    logic [DN_W-1:0] first_dn;
    logic [DN_W-1:0] second_dn;

    logic                    r_v1, r_v2, r_v3;
    logic                    r_cmd1, r_cmd2;
    logic signed [OFF_W-1:0] r_off1, r_off2;

    logic signed [24:0] shift_sum;
    logic signed [23:0] raw_diff;
    logic [NUM_W-1:0]   n_num;
    t_side              n_side;
    logic [NUM_W-1:0]   r_num;
    t_side              r_side;

    logic              d_valid;
    t_side             d_side;
    logic [YEAR_W-1:0] d_year;
    logic [MON_W-1:0]  d_month;
    logic [DAY_W-1:0]  d_day;

    logic                    r_valid;
    logic [YEAR_W-1:0]       r_year;
    logic [MON_W-1:0]        r_month;
    logic [DAY_W-1:0]        r_day;
    logic signed [OFF_W-1:0] r_diff;
    logic                    r_err;

    assign busy = 1'b0;

    gdau_to_days u_first_days (
        .i_clk     (i_clk),
        .i_year    (i_first_year),
        .i_month   (i_first_month),
        .i_day     (i_first_day),
        .o_day_num (first_dn)
    );

    gdau_to_days u_second_days (
        .i_clk     (i_clk),
        .i_year    (i_second_year),
        .i_month   (i_second_month),
        .i_day     (i_second_day),
        .o_day_num (second_dn)
    );

    // Command and offset travel beside the day number conversion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1 <= i_command;
        r_off1 <= i_day_offset;
        r_cmd2 <= r_cmd1;
        r_off2 <= r_off1;
        r_num  <= n_num;
        r_side <= n_side;
    end

    always_comb begin
        shift_sum   = $signed({2'b00, first_dn}) + 25'(r_off2);
        raw_diff    = $signed({1'b0, second_dn}) - $signed({1'b0, first_dn});
        n_num       = DN_LO;
        n_side.cmd  = r_cmd2;
        n_side.err  = 1'b0;
        n_side.diff = '0;
        if (r_cmd2 == CMD_ADD) begin
            if (shift_sum < $signed({3'b000, DN_LO})) begin
                n_side.err = 1'b1;
            end else if (shift_sum > $signed({3'b000, DN_HI})) begin
                n_num      = DN_HI;
                n_side.err = 1'b1;
            end else begin
                n_num = shift_sum[NUM_W-1:0];
            end
        end else begin
            // The two top bits differ only when the difference overflows.
            if (!raw_diff[23] && raw_diff[22]) begin
                n_side.diff = $signed(DIFF_MAX);
                n_side.err  = 1'b1;
            end else if (raw_diff[23] && !raw_diff[22]) begin
                n_side.diff = $signed(DIFF_MIN);
                n_side.err  = 1'b1;
            end else begin
                n_side.diff = raw_diff[22:0];
            end
        end
    end

    gdau_to_date u_to_date (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v3),
        .i_side    (r_side),
        .i_day_num (r_num),
        .o_valid   (d_valid),
        .o_side    (d_side),
        .o_year    (d_year),
        .o_month   (d_month),
        .o_day     (d_day)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_side.cmd == CMD_DIFF) begin
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
        end else begin
            r_year  <= d_year;
            r_month <= d_month;
            r_day   <= d_day;
        end
        r_diff <= d_side.diff;
        r_err  <= d_side.err;
    end

    assign o_valid          = r_valid;
    assign o_result_year    = r_year;
    assign o_result_month   = r_month;
    assign o_result_day     = r_day;
    assign o_day_difference = r_diff;
    assign o_range_error    = r_err;

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##12 o_valid)
        else $error("request did not produce a result after 12 cycles");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 12))
        else $error("result without a matching request");

    a_saturated_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error && o_result_month != 4'd0) |->
        ((o_result_year == 14'd0 && o_result_month == 4'd1 && o_result_day == 5'd1) ||
         (o_result_year == 14'd9999 && o_result_month == 4'd12 && o_result_day == 5'd31)))
        else $error("range error without a clamped date");

    a_commands_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_day_difference != 23'sd0) |->
        (o_result_year == 14'd0 && o_result_month == 4'd0 && o_result_day == 5'd0))
        else $error("date fields set on a difference result");

    a_date_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_month != 4'd0) |->
        (o_result_month <= 4'd12 && o_result_day >= 5'd1 && o_result_day <= 5'd31))
        else $error("shifted date has an illegal month or day");

endmodule
